@@ hw/rtl/dsrg_pkg.sv @@
// ----------------------------------------------------------------------------
// dsrg_pkg
// Types and fixed constants shared by the dual stepper rate generator files.
// ----------------------------------------------------------------------------
package dsrg_pkg;

  localparam int RATE_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int K_W        = 24;
  localparam int DB_W       = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [K_W-1:0]      K_RESET      = 24'd111616;
  localparam logic [DB_W-1:0]     DB_RESET     = 15'd51;
  localparam logic [PERIOD_W-1:0] IDLE_DIVISOR = 16'd255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE_CONSTANT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND           = 1'b1;

  // Function codes of an input item.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_RATE = 1'b1;

  typedef struct packed {
    logic                     func;
    logic signed [RATE_W-1:0] rate_left;
    logic signed [RATE_W-1:0] rate_right;
  } in_item_t;

  typedef struct packed {
    logic                step_left;
    logic                step_right;
    logic                dir_left;
    logic                dir_right;
    logic [PERIOD_W-1:0] period_left;
    logic [PERIOD_W-1:0] period_right;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic start;
  } wheel_ctl_t;

  typedef struct packed {
    logic                step;
    logic                dir;
    logic [PERIOD_W-1:0] period;
    logic                done;
  } wheel_stat_t;

endpackage

@@ hw/rtl/dsrg_div.sv @@
// ----------------------------------------------------------------------------
// dsrg_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module dsrg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dsrg_pkg::K_W-1:0]      dividend,
  input  logic [dsrg_pkg::RATE_W-1:0]   divisor,
  output logic                          done,
  output logic [dsrg_pkg::K_W-1:0]      quotient
);

  localparam int DVD_W = dsrg_pkg::K_W;
  localparam int DVS_W = dsrg_pkg::RATE_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  // Holds the dividend; quotient bits shift in from the bottom.
  logic [DVD_W-1:0] dvd_r;

  logic [DVS_W:0]   trial;
  logic             qbit;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ hw/rtl/dsrg_wheel.sv @@
// ----------------------------------------------------------------------------
// dsrg_wheel
// One wheel: tick counter, divisor and direction, with a serial divider that
// turns a rate into a new divisor.
// ----------------------------------------------------------------------------
module dsrg_wheel #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dsrg_pkg::wheel_ctl_t                   ctl,
  input  logic signed [dsrg_pkg::RATE_W-1:0]     rate,
  input  logic [dsrg_pkg::K_W-1:0]               k,
  input  logic [dsrg_pkg::DB_W-1:0]              deadband,
  output dsrg_pkg::wheel_stat_t                  stat
);

  localparam int PW    = dsrg_pkg::PERIOD_W;
  localparam int QW    = dsrg_pkg::K_W;
  localparam int CMP_W = (COUNT_BITS > PW) ? COUNT_BITS : PW;
  localparam logic [PW-1:0] DIV_MAX = (COUNT_BITS >= PW) ? {PW{1'b1}} :
                                      PW'((64'd1 << COUNT_BITS) - 64'd1);

  logic [COUNT_BITS-1:0] count_r;
  logic [PW-1:0]         divisor_r;
  logic                  dir_r;
  logic                  neg_r;
  logic                  idle_r;

  logic                  neg;
  logic [PW-1:0]         mag;
  logic                  step;
  logic                  div_done;
  logic [QW-1:0]         quot;
  logic [QW-1:0]         quot_m1;
  logic [PW-1:0]         sat_div;

  // The most negative rate has magnitude 32768, which still fits unsigned.
  assign neg = rate[dsrg_pkg::RATE_W-1];
  assign mag = neg ? PW'(PW'(0) - $unsigned(rate)) : $unsigned(rate);

  assign step = (CMP_W'(count_r) >= CMP_W'(divisor_r));

  dsrg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.start),
    .dividend (k),
    .divisor  (mag),
    .done     (div_done),
    .quotient (quot)
  );

  assign quot_m1 = quot - QW'(1);

  always_comb begin
    if (quot == '0) begin
      sat_div = '0;
    end else if (quot_m1 > QW'(DIV_MAX)) begin
      sat_div = DIV_MAX;
    end else begin
      sat_div = quot_m1[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      divisor_r <= '0;
      dir_r     <= 1'b0;
    end else begin
      if (ctl.tick) begin
        count_r <= step ? '0 : count_r + COUNT_BITS'(1);
      end
      if (div_done) begin
        if (idle_r) begin
          divisor_r <= dsrg_pkg::IDLE_DIVISOR;
        end else begin
          divisor_r <= sat_div;
          dir_r     <= neg_r;
        end
      end
    end
  end

  // Sign and deadband decision are taken when the rate arrives; the divider
  // runs anyway and its result is dropped for an idling wheel.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg_r  <= neg;
      idle_r <= (mag <= {1'b0, deadband});
    end
  end

  assign stat.step   = step;
  assign stat.dir    = dir_r;
  assign stat.period = divisor_r;
  assign stat.done   = div_done;

endmodule

@@ hw/rtl/dual_stepper_rate_generator.sv @@
// ----------------------------------------------------------------------------
// dual_stepper_rate_generator
// Step pulse generator for two stepper wheels with bit-serial rate division.
//
//   channel  ports                          direction  payload
//   input    in_valid/in_ready/in_data      in         dsrg_pkg::in_item_t
//   result   out_valid/out_ready/out_data   out        dsrg_pkg::out_item_t
//   config   cfg_we/cfg_index/cfg_data      in         24-bit write data
//
// A tick item's result is registered on the accepting edge. For a rate item,
// both wheels run a 24-step serial divider in parallel (one quotient bit per
// cycle), then the wheels take the new divisors and the load state fills the
// result register. Only one rate item is in flight at a time. Reset is
// synchronous; it clears counters, divisors, directions and out_valid and
// reloads the config registers. A stalled result holds in the output register;
// a new item is taken in the same cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module dual_stepper_rate_generator #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  dsrg_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dsrg_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [dsrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsrg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t                         state_r;
  state_t                         state_nxt;
  logic [dsrg_pkg::K_W-1:0]       k_r;
  logic [dsrg_pkg::DB_W-1:0]      db_r;
  logic                           out_valid_r;
  dsrg_pkg::out_item_t            out_data_r;
  dsrg_pkg::out_item_t            out_data_nxt;

  logic                           in_acc;
  logic                           tick_acc;
  logic                           rate_acc;
  logic                           load_out;
  dsrg_pkg::wheel_ctl_t           ctl;
  dsrg_pkg::wheel_stat_t          stat_l;
  dsrg_pkg::wheel_stat_t          stat_r;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (in_data.func == dsrg_pkg::FUNC_TICK);
  assign rate_acc = in_acc && (in_data.func == dsrg_pkg::FUNC_RATE);

  assign ctl.tick  = tick_acc;
  assign ctl.start = rate_acc;

  dsrg_wheel #(.COUNT_BITS(COUNT_BITS)) u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rate     (in_data.rate_left),
    .k        (k_r),
    .deadband (db_r),
    .stat     (stat_l)
  );

  dsrg_wheel #(.COUNT_BITS(COUNT_BITS)) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rate     (in_data.rate_right),
    .k        (k_r),
    .deadband (db_r),
    .stat     (stat_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= dsrg_pkg::K_RESET;
      db_r <= dsrg_pkg::DB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dsrg_pkg::CFG_STEP_RATE_CONSTANT: k_r  <= cfg_data[dsrg_pkg::K_W-1:0];
        dsrg_pkg::CFG_DEADBAND:           db_r <= cfg_data[dsrg_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (rate_acc) state_nxt = ST_DIV;
      ST_DIV:  if (stat_l.done) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // In the load state the wheels already hold the new divisors, and the
  // result register was freed when the rate item was accepted.
  assign load_out = tick_acc || (state_r == ST_LOAD);

  always_comb begin
    out_data_nxt.step_left    = tick_acc && stat_l.step;
    out_data_nxt.step_right   = tick_acc && stat_r.step;
    out_data_nxt.dir_left     = stat_l.dir;
    out_data_nxt.dir_right    = stat_r.dir;
    out_data_nxt.period_left  = stat_l.period;
    out_data_nxt.period_right = stat_r.period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/dsrg_chk.sv @@
// ----------------------------------------------------------------------------
// dsrg_chk
// Port-level checks for the dual stepper rate generator, bound to the top.
// ----------------------------------------------------------------------------
module dsrg_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input dsrg_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input dsrg_pkg::out_item_t             out_data
);

  // A waiting result must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A tick item yields its result on the next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == dsrg_pkg::FUNC_TICK) |=> out_valid)
    else $error("tick item gave no result");

  // Just after a rate item is taken, no result is valid and input is blocked.
  a_rate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == dsrg_pkg::FUNC_RATE)
    |=> !out_valid && !in_ready)
    else $error("rate item overlapped another item");

  // An item is only taken when the result register can accept its result.
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input ready while result register is blocked");

endmodule

bind dual_stepper_rate_generator dsrg_chk u_dsrg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
